>>> hdl/minmax_peak_span_decimator_top_macros.svh
// assertion macros used by the checker of the peak-span decimator
`ifndef MINMAX_PEAK_SPAN_DECIMATOR_TOP_MACROS_SVH
`define MINMAX_PEAK_SPAN_DECIMATOR_TOP_MACROS_SVH

// same-cycle implication, off while reset is high
`define MMPSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off while reset is high
`define MMPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also watches reset itself
`define MMPSD_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/mmpsd_pkg.sv
package mmpsd_pkg;

   localparam int MAX_CHANNELS_DEF = 8;
   localparam int MAX_BUCKETS_DEF  = 4096;

   localparam int SAMPLE_W     = 16;
   localparam int SPAN_W       = 16;
   localparam int BUCKET_W     = 12;
   localparam int CHAN_OUT_W   = 3;
   localparam int CH_CNT_W     = 4;
   localparam int LEN_W        = 31;
   localparam int NB_W         = 13;
   localparam int ACC_W        = 44;
   localparam int CMP_W        = ACC_W + 2;
   localparam int RSP_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = LEN_W;
   localparam int OUT_Q_DEPTH  = 4;

   localparam logic [CH_CNT_W-1:0] CH_CNT_RESET = 4'd2;
   localparam logic [LEN_W-1:0]    LEN_RESET    = '0;
   localparam logic [NB_W-1:0]     NB_RESET     = 13'd1000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_WAVE_LENGTH   = 2'd1,
      CSR_BUCKET_COUNT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SPAN_W-1:0]     span;
      logic [BUCKET_W-1:0]   bucket_index;
      logic [CHAN_OUT_W-1:0] channel;
      logic                  last;
      logic                  config_error;
   } rsp_item_type;

endpackage

>>> hdl/mmpsd_ram.sv
module mmpsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hdl/mmpsd_out_q.sv
module mmpsd_out_q (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mmpsd_pkg::rsp_item_type   push_item,
   input  logic                      pop,
   output logic                      head_valid,
   output mmpsd_pkg::rsp_item_type   head_item,
   output logic [$clog2(mmpsd_pkg::OUT_Q_DEPTH+1)-1:0] count
);
   import mmpsd_pkg::*;

   localparam int PTR_W = $clog2(OUT_Q_DEPTH);
   localparam int CNT_W = $clog2(OUT_Q_DEPTH + 1);

   rsp_item_type       slot_ff [OUT_Q_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

>>> hdl/minmax_peak_span_decimator_top.sv
// channel  direction  handshake            payload
// req      in         req_tvalid/tready    tdata: sample; tuser: first
// rsp      out        rsp_tvalid/tready    tdata: span, bucket_index, channel; tlast; tuser
// csr      in         csr_valid/ready      csr_addr: register index; csr_wdata: value
//
// one sample per clock while req_tready is high; counters and bucket edges settle in the accept cycle
// min/max live in one ram with a registered read, read-modify-write in the cycle after the accept
// a result passes the update stage and then the output queue on its way to rsp
// sync reset zeroes counters and queue, loads config defaults; min/max ram is not cleared
// req stalls once queued results plus the one in the update stage fill the four-entry queue
module minmax_peak_span_decimator_top #(
   parameter int MAX_CHANNELS = mmpsd_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_BUCKETS  = mmpsd_pkg::MAX_BUCKETS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mmpsd_pkg::SAMPLE_W-1:0]     req_tdata,   // [15:0] sample
   input  logic                               req_tuser,   // [0] first
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mmpsd_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [15:0] span, [27:16] bucket_index,
                                                           // [30:28] channel, [31] zero
   output logic                               rsp_tlast,   // last
   output logic                               rsp_tuser,   // [0] config_error
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mmpsd_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [mmpsd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mmpsd_pkg::*;

   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CHE_W = $clog2(MAX_CHANNELS + 1);
   localparam int NBE_W = $clog2(MAX_BUCKETS + 1);
   localparam int Q_CNT_W = $clog2(OUT_Q_DEPTH + 1);

   // configuration registers
   logic [CH_CNT_W-1:0] cfg_ch_ff;
   logic [LEN_W-1:0]    cfg_len_ff;
   logic [NB_W-1:0]     cfg_nb_ff;

   // wave position counters
   logic [CH_W-1:0]     chan_pos_ff, chan_pos_in;
   logic [BUCKET_W-1:0] bucket_pos_ff, bucket_pos_in;
   logic [ACC_W-1:0]    frame_acc_ff, frame_acc_in;
   logic [ACC_W-1:0]    bucket_acc_ff, bucket_acc_in;

   // accept-cycle decode
   logic                accept;
   logic [CHE_W-1:0]    ch_eff;
   logic [NBE_W-1:0]    nb_eff;
   logic [CH_W-1:0]     cp;
   logic [BUCKET_W-1:0] bp;
   logic [ACC_W-1:0]    fa;
   logic [ACC_W-1:0]    ba;
   logic                too_short;
   logic                opening;
   logic                closing;
   logic                chan_wrap;
   logic                bucket_end;

   // update stage
   logic                       s1_valid_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic                       s1_open_ff;
   logic                       s1_close_ff;
   logic                       s1_last_ff;
   logic                       s1_err_ff;
   logic [BUCKET_W-1:0]        s1_bucket_ff;
   logic [CH_W-1:0]            s1_chan_ff;

   // last ram write, for read-during-write forwarding
   logic                       fwd_valid_ff;
   logic [CH_W-1:0]            fwd_addr_ff;
   logic [2*SAMPLE_W-1:0]      fwd_data_ff;

   logic [2*SAMPLE_W-1:0]      ram_rd_data;
   logic [2*SAMPLE_W-1:0]      ram_wr_data;
   logic                       ram_wr_en;
   logic signed [SAMPLE_W-1:0] cur_min, cur_max, new_min, new_max;
   logic [2*SAMPLE_W-1:0]      cur_pair;

   rsp_item_type               push_item;
   rsp_item_type               head_item;
   logic                       push;
   logic [Q_CNT_W-1:0]         q_count;

   // registers always take a write
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ch_ff  <= CH_CNT_RESET;
         cfg_len_ff <= LEN_RESET;
         cfg_nb_ff  <= NB_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_addr))
            CSR_CHANNEL_COUNT: cfg_ch_ff  <= csr_wdata[CH_CNT_W-1:0];
            CSR_WAVE_LENGTH:   cfg_len_ff <= csr_wdata[LEN_W-1:0];
            CSR_BUCKET_COUNT:  cfg_nb_ff  <= csr_wdata[NB_W-1:0];
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // room for one more request: update stage plus queued results stay within the queue
   assign req_tready = (32'(q_count) + 32'(s1_valid_ff)) < OUT_Q_DEPTH;
   assign accept     = req_tvalid && req_tready;

   // clamp configured counts into range
   always_comb begin
      if (cfg_ch_ff == '0) begin
         ch_eff = CHE_W'(1);
      end else if (32'(cfg_ch_ff) > MAX_CHANNELS) begin
         ch_eff = CHE_W'(MAX_CHANNELS);
      end else begin
         ch_eff = CHE_W'(cfg_ch_ff);
      end
      if (cfg_nb_ff == '0) begin
         nb_eff = NBE_W'(1);
      end else if (32'(cfg_nb_ff) > MAX_BUCKETS) begin
         nb_eff = NBE_W'(MAX_BUCKETS);
      end else begin
         nb_eff = NBE_W'(cfg_nb_ff);
      end
   end

   // counters as seen by this sample: first restarts the wave
   always_comb begin
      cp = req_tuser ? '0 : chan_pos_ff;
      bp = req_tuser ? '0 : bucket_pos_ff;
      fa = req_tuser ? '0 : frame_acc_ff;
      ba = req_tuser ? '0 : bucket_acc_ff;

      too_short  = 32'(cfg_len_ff) < 32'(nb_eff);
      // bucket edges by cross multiplication: frame*nb against bucket*len
      opening    = (CMP_W'(fa) + CMP_W'(nb_eff)) > CMP_W'(ba);
      closing    = (CMP_W'(fa) + (CMP_W'(nb_eff) << 1)) > (CMP_W'(ba) + CMP_W'(cfg_len_ff));
      chan_wrap  = (32'(cp) + 32'd1) >= 32'(ch_eff);
      bucket_end = (32'(bp) + 32'd1) >= 32'(nb_eff);

      chan_pos_in   = cp;
      bucket_pos_in = bp;
      frame_acc_in  = fa;
      bucket_acc_in = ba;
      if (!too_short) begin
         if (chan_wrap) begin
            chan_pos_in = '0;
            if (closing && bucket_end) begin
               // final bucket done, next sample opens a new wave
               bucket_pos_in = '0;
               frame_acc_in  = '0;
               bucket_acc_in = '0;
            end else begin
               if (closing) begin
                  bucket_pos_in = bp + BUCKET_W'(1);
                  bucket_acc_in = ba + ACC_W'(cfg_len_ff);
               end
               frame_acc_in = fa + ACC_W'(nb_eff);
            end
         end else begin
            chan_pos_in = cp + CH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff   <= '0;
         bucket_pos_ff <= '0;
         frame_acc_ff  <= '0;
         bucket_acc_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            chan_pos_ff   <= chan_pos_in;
            bucket_pos_ff <= bucket_pos_in;
            frame_acc_ff  <= frame_acc_in;
            bucket_acc_ff <= bucket_acc_in;
         end
         s1_valid_ff  <= accept;
         fwd_valid_ff <= ram_wr_en;
      end
   end

   // update stage payload
   always_ff @(posedge clock) begin
      s1_sample_ff <= req_tdata;
      s1_open_ff   <= opening;
      s1_close_ff  <= closing;
      s1_last_ff   <= closing && bucket_end && chan_wrap;
      s1_err_ff    <= too_short;
      s1_bucket_ff <= bp;
      s1_chan_ff   <= cp;
      fwd_addr_ff  <= s1_chan_ff;
      fwd_data_ff  <= ram_wr_data;
   end

   // running min/max per channel, {max, min}
   mmpsd_ram #(
      .WIDTH (2 * SAMPLE_W),
      .DEPTH (MAX_CHANNELS)
   ) u_minmax_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_chan_ff),
      .wr_data (ram_wr_data),
      .rd_addr (cp),
      .rd_data (ram_rd_data)
   );

   // the ram returns old data when the previous sample wrote the same channel
   always_comb begin
      cur_pair = (fwd_valid_ff && (fwd_addr_ff == s1_chan_ff)) ? fwd_data_ff : ram_rd_data;
      cur_min  = cur_pair[SAMPLE_W-1:0];
      cur_max  = cur_pair[2*SAMPLE_W-1:SAMPLE_W];
      if (s1_open_ff) begin
         new_min = s1_sample_ff;
         new_max = s1_sample_ff;
      end else begin
         new_min = (s1_sample_ff < cur_min) ? s1_sample_ff : cur_min;
         new_max = (s1_sample_ff > cur_max) ? s1_sample_ff : cur_max;
      end
      ram_wr_data = {new_max, new_min};
      ram_wr_en   = s1_valid_ff && !s1_err_ff;
   end

   // result item
   always_comb begin
      push = s1_valid_ff && (s1_err_ff || s1_close_ff);
      push_item.channel = CHAN_OUT_W'(s1_chan_ff);
      if (s1_err_ff) begin
         push_item.span         = '0;
         push_item.bucket_index = '0;
         push_item.last         = 1'b0;
         push_item.config_error = 1'b1;
      end else begin
         push_item.span         = SPAN_W'(new_max - new_min);
         push_item.bucket_index = s1_bucket_ff;
         push_item.last         = s1_last_ff;
         push_item.config_error = 1'b0;
      end
   end

   mmpsd_out_q u_out_q (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (rsp_tready),
      .head_valid (rsp_tvalid),
      .head_item  (head_item),
      .count      (q_count)
   );

   assign rsp_tdata = {1'b0, head_item.channel, head_item.bucket_index, head_item.span};
   assign rsp_tlast = head_item.last;
   assign rsp_tuser = head_item.config_error;
endmodule

>>> hdl/mmpsd_checker.sv
`include "minmax_peak_span_decimator_top_macros.svh"

module mmpsd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mmpsd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast,
   input logic                             rsp_tuser
);
   import mmpsd_pkg::*;

   // an error result carries zero span and bucket and never ends a wave
   `MMPSD_ASSERT_NOW(a_err_zero, rsp_tvalid && rsp_tuser, (rsp_tdata[27:0] == 28'd0) && !rsp_tlast, "error result with nonzero fields")

   // a stalled result holds
   `MMPSD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result changed")

   // reset empties the result queue
   `MMPSD_ASSERT_RST(a_rst_empty, reset, !rsp_tvalid, "result valid after reset")
endmodule

bind minmax_peak_span_decimator_top mmpsd_checker u_mmpsd_checker (.*);

>>> tb/sv/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import mmpsd_pkg::*;

   // run limits
   // slowest correct run: about 1150 requests, each with a random sender gap
   // and one result behind a sparse ready of 1 in 8; the limit is that run taken ten times
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;      // two-stage pipe plus four-entry queue
   localparam int unsigned RANDOM_ITEMS = 750;
   localparam int unsigned MAX_CH       = MAX_CHANNELS_DEF;
   localparam int unsigned MAX_BKT      = MAX_BUCKETS_DEF;

   // receiver stall patterns
   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_HALF,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   // dut ports, all inputs known from time zero
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [SAMPLE_W-1:0]     req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // register mirror, starts at the reset values
   logic [CH_CNT_W-1:0]     cfg_channels = CH_CNT_RESET;
   logic [LEN_W-1:0]        cfg_wave_len = LEN_RESET;
   logic [NB_W-1:0]         cfg_buckets  = NB_RESET;

   // decimator state mirror
   int unsigned             chan_pos   = 0;
   int unsigned             bucket_pos = 0;
   logic [ACC_W-1:0]        frame_acc  = '0;   // frames seen times bucket count
   logic [ACC_W-1:0]        bucket_acc = '0;   // buckets closed times wave length
   logic signed [15:0]      run_lo[MAX_CH] = '{default: '0};
   logic signed [15:0]      run_hi[MAX_CH] = '{default: '0};

   // spans predicted but not yet seen on rsp
   rsp_item_type            pending_spans[$];
   rsp_item_type            want;
   int unsigned             mismatches  = 0;
   int unsigned             cycle_count = 0;

   // sender burst control
   int unsigned             burst_left = 0;
   int unsigned             gap_len    = 0;

   // receiver stall control
   ready_mode_type          ready_mode = READY_ALWAYS;
   int unsigned             ready_left = 0;

   minmax_peak_span_decimator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // out-of-range channel counts clamp to 1..MAX_CH
   function automatic int unsigned effective_channels(input int unsigned raw);
      if (raw == 0) return 1;
      if (raw > MAX_CH) return MAX_CH;
      return raw;
   endfunction

   // out-of-range bucket counts clamp to 1..MAX_BKT
   function automatic int unsigned effective_buckets(input int unsigned raw);
      if (raw == 0) return 1;
      if (raw > MAX_BKT) return MAX_BKT;
      return raw;
   endfunction

   function automatic void restart_counters();
      chan_pos   = 0;
      bucket_pos = 0;
      frame_acc  = '0;
      bucket_acc = '0;
   endfunction

   // advance the mirror by one sample and work out the span it closes, if any
   function automatic void decimate_sample(input logic [15:0] smp, input logic restart_flag,
                                           output logic emits, output rsp_item_type span_item);
      int unsigned        ch_eff;
      int unsigned        nb_eff;
      int unsigned        c;
      longint unsigned    n;
      longint unsigned    wlen;
      logic signed [15:0] s;
      logic               opening;
      logic               closing;
      s         = smp;
      ch_eff    = effective_channels(32'(cfg_channels));
      nb_eff    = effective_buckets(32'(cfg_buckets));
      n         = 64'(nb_eff);
      wlen      = 64'(cfg_wave_len);
      emits     = 1'b0;
      span_item = '0;
      if (restart_flag) restart_counters();
      // short or empty wave: flag every sample, counters hold
      if (wlen < n) begin
         span_item.channel      = chan_pos[2:0];
         span_item.config_error = 1'b1;
         emits                  = 1'b1;
         return;
      end
      c       = (chan_pos >= MAX_CH) ? MAX_CH - 1 : chan_pos;
      // bucket edges from the cross-multiplied accumulators
      opening = (frame_acc + n) > bucket_acc;
      closing = (frame_acc + 2 * n) > (bucket_acc + wlen);
      if (opening) begin
         run_lo[c] = s;
         run_hi[c] = s;
      end else begin
         if (s < run_lo[c]) run_lo[c] = s;
         if (s > run_hi[c]) run_hi[c] = s;
      end
      if (closing) begin
         emits                  = 1'b1;
         span_item.span         = run_hi[c] - run_lo[c];
         span_item.bucket_index = bucket_pos[11:0];
         span_item.channel      = chan_pos[2:0];
         span_item.last         = (bucket_pos + 1 >= nb_eff) && (chan_pos + 1 >= ch_eff);
      end
      if (chan_pos + 1 >= ch_eff) begin
         chan_pos = 0;
         if (closing && bucket_pos + 1 >= nb_eff) begin
            // final bucket done, next sample starts a fresh wave
            restart_counters();
            return;
         end
         if (closing) begin
            bucket_pos = (bucket_pos + 1) % 4096;
            bucket_acc = ACC_W'(bucket_acc + wlen);
         end
         frame_acc = ACC_W'(frame_acc + n);
      end else begin
         chan_pos++;
      end
   endfunction

   // mostly random samples, with the two extremes now and then
   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // one request, sent in bursts with random gaps between them
   task automatic send_sample(input logic [15:0] smp, input logic first_flag);
      logic         emits;
      rsp_item_type span_item;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap_len != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= first_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decimate_sample(smp, first_flag, emits, span_item);
      if (emits) pending_spans.push_back(span_item);
   endtask

   // drop valid, let every span drain, then give the pipe time to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; valid stays high for the caller to drop
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CHANNEL_COUNT: cfg_channels = value[CH_CNT_W-1:0];
         CSR_WAVE_LENGTH:   cfg_wave_len = value[LEN_W-1:0];
         CSR_BUCKET_COUNT:  cfg_buckets  = value[NB_W-1:0];
         default: begin
            // unmapped index, nothing to mirror
         end
      endcase
   endtask

   // all three registers back to back, only while the block is idle
   task automatic configure(input logic [CH_CNT_W-1:0] channels,
                            input logic [LEN_W-1:0] wave_len,
                            input logic [NB_W-1:0] buckets);
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(channels));
      write_reg(CSR_WAVE_LENGTH, CSR_DATA_W'(wave_len));
      write_reg(CSR_BUCKET_COUNT, CSR_DATA_W'(buckets));
      csr_valid <= 1'b0;
   endtask

   // eight-channel wave first so every min/max entry is written before any later read;
   // fifteen channels clamp to eight, zero channels act as one
   task automatic test_channel_saturation();
      logic [15:0] extremes[8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                   16'h0001, 16'h5555, 16'hAAAA, 16'hFFFE};
      int          i;
      configure(4'd15, 31'd1, 13'd1);
      for (i = 0; i < 8; i++) send_sample(extremes[i], i == 0);
      settle();
      configure(4'd0, 31'd2, 13'd1);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      settle();
   endtask

   // wave shorter than the bucket count, empty wave, bucket count of zero
   task automatic test_short_wave();
      configure(4'd2, 31'd0, 13'd1);
      send_sample(16'h1234, 1'b0);
      send_sample(16'hEDCB, 1'b1);
      send_sample(16'h0F0F, 1'b0);
      settle();
      // 8191 buckets clamp to 4096, still one more than the wave's 4095 frames
      configure(4'd1, 31'd4095, 13'd8191);
      send_sample(16'h7FFF, 1'b1);
      settle();
      configure(4'd3, 31'd1, 13'd0);
      send_sample(16'h8001, 1'b1);
      send_sample(16'h00FF, 1'b0);
      send_sample(16'hFF00, 1'b0);
      settle();
   endtask

   // registers change with the counters mid-wave, then the wave runs past its end
   task automatic test_mid_wave_change();
      int i;
      configure(4'd1, 31'd6, 13'd4);
      send_sample(16'h4000, 1'b1);
      send_sample(16'hC000, 1'b0);
      settle();
      configure(4'd2, 31'd6, 13'd1);
      for (i = 0; i < 8; i++) send_sample(random_sample(), 1'b0);
      settle();
   endtask

   // largest bucket count over the opening of a wave, then the longest wave length
   task automatic test_widest_decimation();
      int i;
      configure(4'd1, 31'd4096, 13'd8191);
      for (i = 0; i < 192; i++) send_sample(random_sample(), i == 0);
      settle();
      configure(4'd8, 31'h7FFF_FFFF, 13'd4096);
      for (i = 0; i < 16; i++) send_sample(random_sample(), i == 0);
      settle();
      configure(4'd1, 31'h7FFF_FFFF, 13'd1);
      for (i = 0; i < 8; i++) send_sample(random_sample(), i == 3);
      settle();
   endtask

   // random settings, mostly whole waves with a start marker, some cut short or noisy
   task automatic test_random_waves();
      int unsigned     sent;
      int unsigned     ch_pick;
      int unsigned     nb_pick;
      int unsigned     nb_eff;
      int unsigned     len_pick;
      int unsigned     budget;
      int unsigned     i;
      longint unsigned wave_size;
      longint unsigned left;
      logic            first_flag;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         ch_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         case ($urandom_range(0, 9))
            0:       nb_pick = 0;
            1:       nb_pick = $urandom_range(17, 8191);
            default: nb_pick = $urandom_range(1, 16);
         endcase
         nb_eff = effective_buckets(nb_pick);
         case ($urandom_range(0, 19))
            0:       len_pick = $urandom_range(0, nb_eff - 1);
            1:       len_pick = $urandom_range(1 << 24, 32'h7FFF_FFFF);
            default: len_pick = nb_eff * $urandom_range(1, 3) + $urandom_range(0, nb_eff - 1);
         endcase
         configure(CH_CNT_W'(ch_pick), LEN_W'(len_pick), NB_W'(nb_pick));
         wave_size = longint'(len_pick) * effective_channels(ch_pick);
         if (wave_size == 0) wave_size = 1;
         budget = $urandom_range(20, 150);
         left   = 0;
         for (i = 0; i < budget; i++) begin
            first_flag = 1'b0;
            if (left == 0) begin
               left       = wave_size;
               first_flag = ($urandom_range(0, 3) != 0);
            end
            // noise: stray or missing start marker
            if ($urandom_range(0, 39) == 0) first_flag = ~first_flag;
            left--;
            send_sample(random_sample(), first_flag);
         end
         sent += budget;
         settle();
      end
   endtask

   // receiver ready pattern, switching to a random mode at random intervals
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(16, 200);
      end
      ready_left--;
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_HALF:     rsp_tready <= 1'($urandom_range(0, 1));
         READY_SPARSE:   rsp_tready <= ($urandom_range(0, 7) == 0);
         READY_PERIODIC: rsp_tready <= ready_left[2];
         default:        rsp_tready <= 1'b1;
      endcase
   end

   // result checker: each accepted result against the oldest predicted span
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_spans.size() == 0) begin
            $error("unexpected result: tdata %h tlast %b tuser %b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_spans.pop_front();
            if (rsp_tdata[15:0] !== want.span) begin
               $error("span: expected %0d, actual %0d", want.span, rsp_tdata[15:0]);
               mismatches++;
            end
            if (rsp_tdata[27:16] !== want.bucket_index) begin
               $error("bucket_index: expected %0d, actual %0d",
                      want.bucket_index, rsp_tdata[27:16]);
               mismatches++;
            end
            if (rsp_tdata[30:28] !== want.channel) begin
               $error("channel: expected %0d, actual %0d", want.channel, rsp_tdata[30:28]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               mismatches++;
            end
            if (rsp_tuser !== want.config_error) begin
               $error("config_error: expected %0d, actual %0d", want.config_error, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   // test sequence
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_channel_saturation();
      test_short_wave();
      test_mid_wave_change();
      test_widest_decimation();
      test_random_waves();
      settle();
      if (mismatches == 0 && pending_spans.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
